/* hw/rtl/netstring_deframer_assert.svh */
// assertion macros for the netstring deframer
`ifndef NETSTRING_DEFRAMER_ASSERT_SVH
`define NETSTRING_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define NSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSD_ASSERT(lbl, prop, msg)
`define NSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/nsd_pkg.sv */
package nsd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_COMMA   = 2'd2,
    PH_DROP    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOLEN   = 3'd1,
    ST_TOOLONG = 3'd2,
    ST_BADHDR  = 3'd3,
    ST_NOCOMMA = 3'd4
  } status_t;

  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_COMMA = 8'h2C;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;
  localparam logic        REG_MAX_LEN   = 1'b0;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    logic [2:0] frame_status;
  } result_t;

endpackage

/* hw/rtl/netstring_deframer.sv */
// channel   dir  handshake                 payload
// in_       in   in_tvalid / in_tready     in_tdata = byte_in
// out_      out  out_tvalid / out_tready   out_tdata = payload_byte, out_tlast = frame_done,
//                                          out_tuser = {frame_status, payload_valid}
// cfg_      in   apb write psel&penable    reg 0 at 0x0: max_payload_len [15:0]
//
// one item per cycle sustained while out_tready stays high; each byte gives exactly one result item
// each byte passes the input register, then one pass of the parser into the output register
// the parser state updates in the same cycle the item moves into the output register
// in_tready drops only while both registers hold items and out_tready is low
// rst_n is synchronous; it empties both registers, returns to the header phase
// and sets max_payload_len to 65535
module netstring_deframer
  import nsd_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] payload_byte
  output logic        out_tlast,
  output logic [3:0]  out_tuser,   // [0] payload_valid, [3:1] frame_status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        can_push;
  logic        step;
  result_t     res;
  logic [15:0] max_len_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_LEN) ? {16'h0000, max_len_r} : 32'h0;

  assign step = byte_valid && can_push;

  nsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pop        (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  nsd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (byte_data),
    .max_len (max_len_r),
    .res     (res)
  );

  nsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .res        (res),
    .can_push   (can_push),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/nsd_in_stage.sv */
module nsd_in_stage
  import nsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       pop,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       load;

  // refill in the same cycle the held item moves on
  assign in_tready = !valid_r || pop;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

/* hw/rtl/nsd_parser.sv */
`include "netstring_deframer_assert.svh"

module nsd_parser
  import nsd_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  logic [15:0] max_len,
  output result_t     res
);

  localparam int AW = LEN_BITS + 1;
  localparam int MW = AW + 4;
  localparam int CW = (AW > 17) ? AW : 17;

  phase_t              phase_r, phase_nxt;
  status_t             err_r, err_nxt;
  logic [AW-1:0]       accum_r, accum_nxt;
  logic [LEN_BITS-1:0] left_r, left_nxt;
  logic                saw_r, saw_nxt;

  logic                is_digit;
  logic [MW-1:0]       prod;
  logic [CW-1:0]       cfg_ext, hw_lim, lim;
  logic                too_long;
  logic [LEN_BITS-1:0] left_dec;

  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);

  // accum*10 + digit, saturating when over the accumulator's range
  assign prod = (MW'(accum_r) << 3) + (MW'(accum_r) << 1) + MW'(byte_in[3:0]);

  assign cfg_ext  = CW'(max_len);
  assign hw_lim   = CW'({LEN_BITS{1'b1}});
  assign lim      = (cfg_ext < hw_lim) ? cfg_ext : hw_lim;
  assign too_long = CW'(accum_r) > lim;
  assign left_dec = (left_r == '0) ? '0 : left_r - LEN_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    accum_nxt = accum_r;
    left_nxt  = left_r;
    saw_nxt   = saw_r;
    res       = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (is_digit) begin
          saw_nxt = 1'b1;
          if (prod > MW'({AW{1'b1}})) begin
            accum_nxt = {AW{1'b1}};
          end else begin
            accum_nxt = prod[AW-1:0];
          end
        end else if (byte_in == CH_COLON) begin
          if (!saw_r || accum_r == '0) begin
            err_nxt   = ST_NOLEN;
            phase_nxt = PH_DROP;
          end else if (too_long) begin
            err_nxt   = ST_TOOLONG;
            phase_nxt = PH_DROP;
          end else begin
            left_nxt  = accum_r[LEN_BITS-1:0];
            phase_nxt = PH_PAYLOAD;
          end
        end else if (byte_in == CH_COMMA) begin
          res.frame_done   = 1'b1;
          res.frame_status = saw_r ? ST_BADHDR : ST_NOLEN;
          phase_nxt = PH_HEADER;
          err_nxt   = ST_OK;
          accum_nxt = '0;
          left_nxt  = '0;
          saw_nxt   = 1'b0;
        end else begin
          err_nxt   = ST_BADHDR;
          phase_nxt = PH_DROP;
        end
      end
      PH_PAYLOAD: begin
        res.payload_byte  = byte_in;
        res.payload_valid = 1'b1;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_COMMA;
        end
      end
      PH_COMMA: begin
        if (byte_in == CH_COMMA) begin
          res.frame_done   = 1'b1;
          res.frame_status = ST_OK;
          phase_nxt = PH_HEADER;
          err_nxt   = ST_OK;
          accum_nxt = '0;
          left_nxt  = '0;
          saw_nxt   = 1'b0;
        end else begin
          err_nxt   = ST_NOCOMMA;
          phase_nxt = PH_DROP;
        end
      end
      PH_DROP: begin
        if (byte_in == CH_COMMA) begin
          res.frame_done   = 1'b1;
          res.frame_status = err_r;
          phase_nxt = PH_HEADER;
          err_nxt   = ST_OK;
          accum_nxt = '0;
          left_nxt  = '0;
          saw_nxt   = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      err_r   <= ST_OK;
      accum_r <= '0;
      left_r  <= '0;
      saw_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
      saw_r   <= saw_nxt;
    end
  end

  `NSD_ASSERT(a_payload_has_count, (phase_r == PH_PAYLOAD) |-> (left_r != '0), "payload phase with no bytes left")
  `NSD_ASSERT(a_error_only_in_drop, (phase_r != PH_DROP) |-> (err_r == ST_OK), "error code held outside drop phase")
  `NSD_ASSERT(a_last_payload, (step && phase_r == PH_PAYLOAD && left_r == LEN_BITS'(1)) |=> (phase_r == PH_COMMA), "last payload byte did not move to comma check")
  `NSD_ASSERT(a_done_clears, (step && res.frame_done) |=> (phase_r == PH_HEADER && accum_r == '0 && !saw_r), "frame close did not clear the frame state")

endmodule

/* hw/rtl/nsd_out_stage.sv */
module nsd_out_stage
  import nsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    res,
  output logic       can_push,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [3:0] out_tuser
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_push = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.payload_byte;
  assign out_tlast  = res_r.frame_done;
  assign out_tuser  = {res_r.frame_status, res_r.payload_valid};

endmodule

/* verif/tb_netstring_deframer.sv */
`timescale 1ns / 100ps

module tb_netstring_deframer;
  import nsd_pkg::*;

  localparam int          LEN_BITS     = 16;
  localparam int unsigned ACCUM_CAP    = (1 << (LEN_BITS + 1)) - 1;
  localparam int unsigned HW_LEN_MAX   = (1 << LEN_BITS) - 1;
  localparam logic [2:0]  ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
  localparam logic [2:0]  ADDR_UNUSED  = 3'd4;
  localparam int          LATENCY      = 2;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] byte_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] payload_byte
  logic        out_tlast;
  logic [3:0]  out_tuser;         // [0] payload_valid, [3:1] frame_status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  netstring_deframer #(.LEN_BITS(LEN_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // deframer state as the predictor sees it
  phase_t      frame_phase = PH_HEADER;
  int unsigned len_accum = 0;
  int unsigned bytes_left = 0;
  status_t     pending_error = ST_OK;
  logic        saw_digit = 1'b0;
  logic [15:0] max_len = MAX_LEN_RESET;

  result_t expected_results[$];
  result_t got_expect;

  int src_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  bit hold_start = 1'b0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int input_stalls = 0;
  int quiet_cycles = 0;
  int frames_by_status [5] = '{default: 0};

  function automatic void clear_frame();
    frame_phase   = PH_HEADER;
    len_accum     = 0;
    bytes_left    = 0;
    pending_error = ST_OK;
    saw_digit     = 1'b0;
  endfunction

  function automatic void enter_drop(status_t code);
    pending_error = code;
    frame_phase   = PH_DROP;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     r;
    int unsigned d;
    r = '0;
    case (frame_phase)
      PH_HEADER: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          d = 32'(b - CH_ZERO);
          saw_digit = 1'b1;
          // saturate rather than wrap on absurdly long digit strings
          if (len_accum > (ACCUM_CAP - d) / 10) len_accum = ACCUM_CAP;
          else len_accum = len_accum * 10 + d;
        end else if (b == CH_COLON) begin
          if (!saw_digit || len_accum == 0) enter_drop(ST_NOLEN);
          else if (len_accum > ((max_len < HW_LEN_MAX) ? max_len : HW_LEN_MAX))
            enter_drop(ST_TOOLONG);
          else begin
            bytes_left  = len_accum;
            frame_phase = PH_PAYLOAD;
          end
        end else if (b == CH_COMMA) begin
          r.frame_done   = 1'b1;
          r.frame_status = saw_digit ? ST_BADHDR : ST_NOLEN;
          clear_frame();
        end else begin
          enter_drop(ST_BADHDR);
        end
      end
      PH_PAYLOAD: begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        bytes_left = (bytes_left != 0) ? bytes_left - 1 : 0;
        if (bytes_left == 0) frame_phase = PH_COMMA;
      end
      PH_COMMA: begin
        if (b == CH_COMMA) begin
          r.frame_done   = 1'b1;
          r.frame_status = ST_OK;
          clear_frame();
        end else begin
          enter_drop(ST_NOCOMMA);
        end
      end
      default: begin
        if (b == CH_COMMA) begin
          r.frame_done   = 1'b1;
          r.frame_status = pending_error;
          clear_frame();
        end
      end
    endcase
    return r;
  endfunction

  // called right after a rising edge; returns at the edge that accepts the item
  task automatic send_byte(input logic [7:0] b);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    r = deframe_byte(b);
    expected_results.push_back(r);
    if (r.frame_done) frames_by_status[r.frame_status]++;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number(input int unsigned n, input int zeros);
    repeat (zeros) send_byte(CH_ZERO);
    send_text($sformatf("%0d", n));
  endtask

  task automatic send_junk(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(255)); while (b == CH_COMMA);
      send_byte(b);
    end
  endtask

  task automatic send_good_frame(input int unsigned len);
    send_number(len, ($urandom_range(7) == 0) ? 1 : 0);
    send_byte(CH_COLON);
    repeat (len) send_byte(8'($urandom_range(255)));
    send_byte(CH_COMMA);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_MAX_LEN) max_len = data[15:0];
  endtask

  function automatic int unsigned pick_len(input int unsigned limit);
    int unsigned cap;
    cap = (limit < 12) ? limit : 12;
    if (limit >= 300 && $urandom_range(15) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, cap);
  endfunction

  task automatic test_directed_frames();
    send_text("2:");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_COMMA);
    send_text(":,");      // colon with no digits
    send_text("0:,");     // zero length
    send_text("x,");      // bad header character
    send_text("5,");      // comma after digits, no colon
    send_text(",");       // bare comma
    send_text("1:ab,");   // wrong closing byte
  endtask

  task automatic test_max_len_register();
    send_text("65536:,"); // one over the reset limit
    wait_drained();
    cfg_write(ADDR_MAX_LEN, 32'hFFFF_0005);
    send_good_frame(5);
    send_text("6:,");
    wait_drained();
    cfg_write(ADDR_MAX_LEN, 32'd0);
    send_text("1:,");
    wait_drained();
    // unmapped address must leave the limit alone
    cfg_write(ADDR_UNUSED, 32'd7);
    send_text("1:,");
    wait_drained();
    cfg_write(ADDR_MAX_LEN, 32'd1);
    send_text("1:z,");
    send_text("2:,");
    wait_drained();
    cfg_write(ADDR_MAX_LEN, {16'h0, MAX_LEN_RESET});
  endtask

  task automatic test_backpressure();
    wait_drained();
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_start = 1'b1;
    send_good_frame(24);
    wait_drained();
    send_good_frame(3);
    send_text("7:");
    send_junk(7);
    send_byte(CH_COMMA);
  endtask

  task automatic test_random_traffic(input int src_pct, input int rcv_pct,
                                     input logic [15:0] limit, input int n_items);
    int          stop_at;
    int          kind;
    int unsigned len;
    logic [7:0]  b;
    wait_drained();
    cfg_write(ADDR_MAX_LEN, {16'h0, limit});
    src_idle_pct = src_pct;
    rcv_idle_pct = rcv_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_good_frame(pick_len(limit));
      end else if (kind < 77) begin
        // payload followed by something other than the comma
        len = pick_len(limit);
        send_number(len, 0);
        send_byte(CH_COLON);
        repeat (len) send_byte(8'($urandom_range(255)));
        send_junk($urandom_range(1, 4));
        send_byte(CH_COMMA);
      end else if (kind < 83) begin
        repeat ($urandom_range(0, 2)) send_byte(CH_ZERO + 8'($urandom_range(9)));
        do b = 8'($urandom_range(255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON || b == CH_COMMA);
        send_byte(b);
        send_junk($urandom_range(0, 4));
        send_byte(CH_COMMA);
      end else if (kind < 87) begin
        send_number(int'(limit) + 1 + $urandom_range(0, limit), 0);
        send_byte(CH_COLON);
        send_junk($urandom_range(0, 3));
        send_byte(CH_COMMA);
      end else if (kind < 90) begin
        // enough digits to saturate the length accumulator
        repeat ($urandom_range(7, 9)) send_byte(CH_ZERO + 8'($urandom_range(1, 9)));
        send_byte(CH_COLON);
        send_byte(CH_COMMA);
      end else if (kind < 93) begin
        repeat ($urandom_range(0, 2)) send_byte(CH_ZERO);
        send_byte(CH_COLON);
        send_junk($urandom_range(0, 3));
        send_byte(CH_COMMA);
      end else if (kind < 96) begin
        repeat ($urandom_range(0, 3)) send_byte(CH_ZERO + 8'($urandom_range(9)));
        send_byte(CH_COMMA);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(63) == 0) wait_drained();
    end
  endtask

  // result side: random ready, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: byte %02h last %0b user %04b",
                   out_tdata, out_tlast, out_tuser);
      end else begin
        got_expect = expected_results.pop_front();
        if (out_tdata !== got_expect.payload_byte || out_tuser[0] !== got_expect.payload_valid ||
            out_tlast !== got_expect.frame_done || out_tuser[3:1] !== got_expect.frame_status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("result mismatch: expected byte %02h valid %0b done %0b status %0d,",
                   got_expect.payload_byte, got_expect.payload_valid, got_expect.frame_done,
                   got_expect.frame_status);
            $display(" got byte %02h valid %0b done %0b status %0d",
                     out_tdata, out_tuser[0], out_tlast, out_tuser[3:1]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_max_len_register();
    test_backpressure();
    test_random_traffic(28, 65, 16'd16, 400);
    test_random_traffic(65, 28, MAX_LEN_RESET, 400);
    test_random_traffic(0, 0, 16'($urandom_range(8, 64)), 400);
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d expected result items never arrived", expected_results.size());
    end
    $display("sent %0d bytes, checked %0d result items, input stalled %0d cycles",
             items_sent, results_checked, input_stalls);
    $display("frames closed: ok %0d, no length %0d, too long %0d, bad header %0d, no comma %0d",
             frames_by_status[ST_OK], frames_by_status[ST_NOLEN], frames_by_status[ST_TOOLONG],
             frames_by_status[ST_BADHDR], frames_by_status[ST_NOCOMMA]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* netstring_deframer.f */
+incdir+hw/rtl
hw/rtl/nsd_pkg.sv
hw/rtl/nsd_in_stage.sv
hw/rtl/nsd_parser.sv
hw/rtl/nsd_out_stage.sv
hw/rtl/netstring_deframer.sv
verif/tb_netstring_deframer.sv
